// ----- hdl/crms_pkg.sv -----
// ----------------------------------------------------------------------------
// crms_pkg - shared types and constants of the circle map scorer
// Payload structs, register indexes, sizing defaults and the sequencer states.
// ----------------------------------------------------------------------------
package crms_pkg;

  localparam int unsigned MAP_COLS_MAX_DEF   = 256;
  localparam int unsigned MAP_ROWS_MAX_DEF   = 256;
  localparam int unsigned RADIUS_MAX_DEF     = 31;
  localparam int unsigned RUN_POINTS_MAX_DEF = 4096;

  localparam logic [19:0] SUM_CAP       = 20'hFFFFF;
  localparam int unsigned CNT_FIELD_CAP = 8191;

  localparam logic [0:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [0:0] REG_MAP_HEIGHT = 1'b1;

  localparam logic MODE_DRAW  = 1'b0;
  localparam logic MODE_SCORE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic        [4:0]  radius;
    logic        [7:0]  color;
    logic               last_point;
  } crms_in_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic        inside_map;
    logic [19:0] score_sum;
    logic [12:0] points_total;
    logic [12:0] points_inside;
    logic        run_done;
  } crms_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_BRUSH,
    ST_READ,
    ST_SCORE
  } crms_state_t;

endpackage

// ----- hdl/circle_raster_map_scorer_unit.sv -----
// ----------------------------------------------------------------------------
// circle_raster_map_scorer_unit - likelihood map rasteriser and scorer
// A byte map in one synchronous RAM; circles are drawn into it, points scored.
// ----------------------------------------------------------------------------
// After reset the block clears the map RAM, MAP_COLS_MAX*MAP_ROWS_MAX bytes (65536 at
// the defaults), one byte a cycle. in_ready stays low during the clear, and
// configuration beats are still taken. in_ready is high only while the
// sequencer is idle, so one item is in work at a time.
// A score beat passes through accept, RAM read and accumulate and gives one
// result beat. The accumulate cycle waits while the previous result still sits
// in the output register unclaimed.
// A draw beat gives no result. Its steps are:
//   - the accept;
//   - the four axis points, 5 brush pixels each, and a skip of each of
//     the four unused octant slots;
//   - for each midpoint step, an update and the brushes of the 8 octant
//     points, 5 pixels each, through one RAM write port. The last step has no
//     update after it.
// The number of midpoint steps is near radius/sqrt(2). A brush whose centre
// falls off the map writes nothing and its octant point is passed over. The
// single write port of the map RAM is why brush pixels are written one at a time.
module circle_raster_map_scorer_unit #(
  parameter int unsigned MAP_COLS_MAX   = crms_pkg::MAP_COLS_MAX_DEF,
  parameter int unsigned MAP_ROWS_MAX   = crms_pkg::MAP_ROWS_MAX_DEF,
  parameter int unsigned RADIUS_MAX     = crms_pkg::RADIUS_MAX_DEF,
  parameter int unsigned RUN_POINTS_MAX = crms_pkg::RUN_POINTS_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  crms_pkg::crms_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crms_pkg::crms_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  import crms_pkg::*;

  localparam int unsigned DEPTH = MAP_COLS_MAX * MAP_ROWS_MAX;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CAP_I = (RUN_POINTS_MAX < CNT_FIELD_CAP) ?
                                  RUN_POINTS_MAX : CNT_FIELD_CAP;
  localparam logic [12:0] CNT_CAP = 13'(CAP_I);
  localparam logic [12:0] COLS13  = 13'(MAP_COLS_MAX);
  localparam logic [12:0] ROWS13  = 13'(MAP_ROWS_MAX);
  localparam logic [4:0]  RMAX5   = (RADIUS_MAX > 31) ? 5'd31 : 5'(RADIUS_MAX);

  // map RAM
  logic [7:0]    mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // configuration
  logic [8:0] width_r, height_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  width_r  <= cfg_data;
        REG_MAP_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end
  logic [12:0] eff_w, eff_h;
  assign eff_w = (13'(width_r) < COLS13) ? 13'(width_r) : COLS13;
  assign eff_h = (13'(height_r) < ROWS13) ? 13'(height_r) : ROWS13;

  // sequencer registers
  crms_state_t state_r, state_nxt;
  logic [AW-1:0]      clr_r;
  crms_in_t           item_r;
  logic signed [7:0]  f_r;
  logic [5:0]         x_r, y_r;
  logic [2:0]         oct_r;
  logic [2:0]         br_r;
  logic               score_in_r;
  logic [19:0]        sum_r;
  logic [12:0]        tot_r, ins_r;
  logic               out_valid_r;
  crms_out_t          out_r;

  logic accept;
  logic score_go;   // accumulate cycle may load the output register
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign score_go  = (state_r == ST_SCORE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // point of the current octant, then brush offset
  logic signed [17:0] px, py, bx, by;
  always_comb begin
    logic signed [17:0] cx, cy, xs, ys;
    cx = 18'(item_r.center_x);
    cy = 18'(item_r.center_y);
    xs = 18'(signed'({1'b0, x_r}));
    ys = 18'(signed'({1'b0, y_r}));
    case (oct_r)
      3'd0: begin px = cx + xs; py = cy + ys; end
      3'd1: begin px = cx - xs; py = cy + ys; end
      3'd2: begin px = cx + xs; py = cy - ys; end
      3'd3: begin px = cx - xs; py = cy - ys; end
      3'd4: begin px = cx + ys; py = cy + xs; end
      3'd5: begin px = cx - ys; py = cy + xs; end
      3'd6: begin px = cx + ys; py = cy - xs; end
      default: begin px = cx - ys; py = cy - xs; end
    endcase
    case (br_r)
      3'd0: begin bx = px;          by = py;          end
      3'd1: begin bx = px - 18'sd1; by = py;          end
      3'd2: begin bx = px;          by = py - 18'sd1; end
      3'd3: begin bx = px + 18'sd1; by = py;          end
      default: begin bx = px;       by = py + 18'sd1; end
    endcase
  end

  function automatic logic inmap(input logic signed [17:0] xv, input logic signed [17:0] yv,
                                 input logic [12:0] w, input logic [12:0] h);
    inmap = !xv[17] && !yv[17] && (xv < 18'(signed'({1'b0, w})))
            && (yv < 18'(signed'({1'b0, h})));
  endfunction

  logic centre_in, pix_in, pt_in, score_in;
  assign centre_in = inmap(px, py, eff_w, eff_h);
  assign pix_in    = inmap(bx, by, eff_w, eff_h);
  assign score_in  = inmap(18'(item_r.center_x), 18'(item_r.center_y), eff_w, eff_h);
  assign pt_in     = centre_in;

  // addresses: y*W + x, one multiply each for the brush and the score address
  logic [AW-1:0] baddr, saddr;
  always_comb begin
    logic [25:0] pb, ps;
    pb = 26'(by[12:0]) * 26'(eff_w) + 26'(bx[12:0]);
    ps = 26'(item_r.center_y[12:0]) * 26'(eff_w) + 26'(item_r.center_x[12:0]);
    baddr = pb[AW-1:0];
    saddr = ps[AW-1:0];
  end

  // one round of the four axis points is oct 0..7 with x=0,y=r; octants 0..3
  // give (cx,cy+r),(cx,cy+r),(cx,cy-r),(cx,cy-r), 4..7 give (cx+r,cy),(cx-r,cy)
  // twice, so the axis round uses octants 0,2,4,5 only; x advances between rounds.
  logic axis_r;
  logic oct_live;
  always_comb begin
    if (axis_r) begin
      oct_live = (oct_r == 3'd0) || (oct_r == 3'd2) || (oct_r == 3'd4) || (oct_r == 3'd5);
    end else begin
      oct_live = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_SCORE) begin
            state_nxt = ST_READ;
          end else if ((18'(in_data.center_x) < 18'(signed'({1'b0, eff_w}))) &&
                       (18'(in_data.center_y) < 18'(signed'({1'b0, eff_h})))) begin
            state_nxt = ST_BRUSH;
          end
        end
      end
      ST_BRUSH: begin
        if (br_r == 3'd4 || !oct_live || !pt_in) begin
          if (oct_r == 3'd7) state_nxt = (axis_r || x_r < y_r) ? ST_STEP : ST_IDLE;
        end
      end
      ST_STEP:  state_nxt = (x_r < y_r) ? ST_BRUSH : ST_IDLE;
      ST_READ:  state_nxt = ST_SCORE;
      ST_SCORE: state_nxt = score_go ? ST_IDLE : ST_SCORE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = baddr;
    wdata = item_r.color;
    raddr = saddr;
    unique case (state_r)
      ST_CLEAR: begin we = 1'b1; waddr = clr_r; wdata = 8'd0; end
      ST_BRUSH: we = oct_live && pt_in && pix_in;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      tot_r       <= '0;
      ins_r       <= '0;
    end else begin
      state_r <= state_nxt;
      // raddr holds while the accumulate cycle waits, so rdata_r stays put
      if (score_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + AW'(1);
        ST_IDLE: if (accept) begin
          item_r <= in_data;
          x_r    <= '0;
          y_r    <= (in_data.radius > RMAX5) ? 6'(RMAX5) : 6'(in_data.radius);
          f_r    <= 8'sd1 - 8'(signed'({1'b0, ((in_data.radius > RMAX5) ?
                    RMAX5 : in_data.radius)}));
          oct_r  <= '0;
          br_r   <= '0;
          axis_r <= 1'b1;
        end
        ST_BRUSH: begin
          if (br_r == 3'd4 || !oct_live || !pt_in) begin
            br_r  <= '0;
            oct_r <= oct_r + 3'd1;
          end else begin
            br_r <= br_r + 3'd1;
          end
        end
        ST_STEP: begin
          // midpoint update: ddF_y = -2y+2 after decrement, ddF_x = 2x+3
          axis_r <= 1'b0;
          if (!f_r[7]) begin
            y_r <= y_r - 6'd1;
            f_r <= f_r + 8'sd2 * 8'(signed'({2'b0, x_r})) + 8'sd5
                   - 8'sd2 * 8'(signed'({2'b0, y_r}));
          end else begin
            f_r <= f_r + 8'sd2 * 8'(signed'({2'b0, x_r})) + 8'sd3;
          end
          x_r <= x_r + 6'd1;
        end
        ST_READ: score_in_r <= score_in;
        ST_SCORE: begin
          logic [20:0] s;
          logic [19:0] sv;
          logic [12:0] tv, iv;
          s  = 21'(sum_r) + (score_in_r ? 21'(rdata_r) : 21'd0);
          sv = (s > 21'(SUM_CAP)) ? SUM_CAP : s[19:0];
          tv = (tot_r < CNT_CAP) ? tot_r + 13'd1 : tot_r;
          iv = (score_in_r && ins_r < CNT_CAP) ? ins_r + 13'd1 : ins_r;
          if (score_go) begin
            out_r.pixel_value   <= score_in_r ? rdata_r : 8'd0;
            out_r.inside_map    <= score_in_r;
            out_r.score_sum     <= sv;
            out_r.points_total  <= tv;
            out_r.points_inside <= iv;
            out_r.run_done      <= item_r.last_point;
            sum_r <= item_r.last_point ? '0 : sv;
            tot_r <= item_r.last_point ? '0 : tv;
            ins_r <= item_r.last_point ? '0 : iv;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_result_after_score: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCORE) |=> out_valid) else $error("score gave no result");
  a_no_write_in_score: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_SCORE) |-> !we) else $error("write in score");
`endif

endmodule
